// File: src/mpt_pkg.sv
// Package: widths, item and snapshot types, and back-end state codes.
package mpt_pkg;

    // Sample width and the fixed result width
    localparam int VALUE_WIDTH   = 16;
    localparam int PRODUCT_WIDTH = 47;

    // Full-precision product widths
    localparam int PAIR_WIDTH = 2 * VALUE_WIDTH;
    localparam int PROD_WIDTH = 3 * VALUE_WIDTH;
    localparam int EXT_WIDTH  = (PROD_WIDTH > PRODUCT_WIDTH) ? PROD_WIDTH : PRODUCT_WIDTH;

    // Snapshot queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Extreme values and saturating count limit
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [1:0] SEEN_FULL = 2'd3;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] sample;
        logic                          last;
    } t_in_item;

    typedef struct packed {
        logic signed [PRODUCT_WIDTH-1:0] product;
        logic                            valid_res;
    } t_out_item;

    // Extremes of one finished set
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] large1;
        logic signed [VALUE_WIDTH-1:0] large2;
        logic signed [VALUE_WIDTH-1:0] large3;
        logic signed [VALUE_WIDTH-1:0] small1;
        logic signed [VALUE_WIDTH-1:0] small2;
        logic                          ok;
    } t_snap;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } t_back_state;

endpackage

// File: src/max_product_of_three_tracker.sv
// Top level: maximum product of three values over a stream of sets.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------
//  input    | i_valid / o_ready  | i_item  (sample, last)
//  output   | o_valid / i_ready  | o_item  (product, valid_res)
//
// Samples are taken one per cycle while the snapshot queue has room; the front tracker updates in the same cycle.
// For each set the back end steps through pop, pair multiply, triple multiply and
// emit, in its two-step multiply sequence; emit waits while the output is held.
// A two-entry snapshot queue lets new sets stream in while results wait.
// o_ready drops only when the queue is full; reset is synchronous, active low.
module max_product_of_three_tracker import mpt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    t_queue_status w_status;
    t_snap         w_push_snap, w_pop_snap;
    logic          w_push, w_pop;

    mpt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .i_status (w_status),
        .o_push   (w_push),
        .o_snap   (w_push_snap)
    );

    mpt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_snap   (w_push_snap),
        .i_pop    (w_pop),
        .o_snap   (w_pop_snap),
        .o_status (w_status)
    );

    mpt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .i_snap   (w_pop_snap),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_item   (o_item)
    );

endmodule

// File: src/mpt_front.sv
// Front end: accepts samples and tracks the set's three largest and two smallest values.
module mpt_front import mpt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_in_item      i_item,
    input  t_queue_status i_status,
    output logic          o_push,
    output t_snap         o_snap
);

    logic signed [VALUE_WIDTH-1:0] r_l1, r_l2, r_l3, r_s1, r_s2;
    logic signed [VALUE_WIDTH-1:0] n_l1, n_l2, n_l3, n_s1, n_s2;
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] w_cnt_inc;
    logic       w_acc;

    assign o_ready = !i_status.full;
    assign w_acc   = i_valid && o_ready;

    // Insert the new sample into both sorted lists
    always_comb begin
        n_l1 = r_l1;
        n_l2 = r_l2;
        n_l3 = r_l3;
        n_s1 = r_s1;
        n_s2 = r_s2;
        if (i_item.sample > r_l1) begin
            n_l3 = r_l2;
            n_l2 = r_l1;
            n_l1 = i_item.sample;
        end else if (i_item.sample > r_l2) begin
            n_l3 = r_l2;
            n_l2 = i_item.sample;
        end else if (i_item.sample > r_l3) begin
            n_l3 = i_item.sample;
        end
        if (i_item.sample < r_s1) begin
            n_s2 = r_s1;
            n_s1 = i_item.sample;
        end else if (i_item.sample < r_s2) begin
            n_s2 = i_item.sample;
        end
    end

    // Saturating count of samples in the set
    assign w_cnt_inc = (r_cnt == SEEN_FULL) ? r_cnt : r_cnt + 2'd1;
    assign n_cnt     = w_cnt_inc;

    // Snapshot pushed on the last item of a set
    assign o_push        = w_acc && i_item.last;
    assign o_snap.large1 = n_l1;
    assign o_snap.large2 = n_l2;
    assign o_snap.large3 = n_l3;
    assign o_snap.small1 = n_s1;
    assign o_snap.small2 = n_s2;
    assign o_snap.ok     = (n_cnt == SEEN_FULL);

    // Tracker registers, cleared after each set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_l1  <= VAL_MIN;
            r_l2  <= VAL_MIN;
            r_l3  <= VAL_MIN;
            r_s1  <= VAL_MAX;
            r_s2  <= VAL_MAX;
            r_cnt <= 2'd0;
        end else if (w_acc) begin
            r_l1  <= n_l1;
            r_l2  <= n_l2;
            r_l3  <= n_l3;
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_cnt <= n_cnt;
        end
    end

    // A set boundary leaves the tracker empty
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_cnt == 2'd0 && r_l1 == VAL_MIN && r_s1 == VAL_MAX))
        else $error("tracker not cleared after last item");

    // Sorted order holds inside the lists
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_l1 >= r_l2 && r_l2 >= r_l3 && r_s1 <= r_s2))
        else $error("tracker lists out of order");

endmodule

// File: src/mpt_queue.sv
// Snapshot queue: a short register FIFO between front and back.
module mpt_queue import mpt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_snap         i_snap,
    input  logic          i_pop,
    output t_snap         o_snap,
    output t_queue_status o_status
);

    t_snap               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_CW-1:0] r_cnt;
    logic                w_wr, w_rd;

    assign o_status.full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_wr = i_push && !o_status.full;
    assign w_rd = i_pop && !o_status.empty;
    assign o_snap = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_snap;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= QUEUE_CW'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("snapshot pushed into full queue");

endmodule

// File: src/mpt_back.sv
// Back end: forms both triple products in two multiply steps and picks the larger.
module mpt_back import mpt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_status i_status,
    input  t_snap         i_snap,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output t_out_item     o_item
);

    t_back_state r_state, n_state;
    t_snap       r_snap;
    logic signed [PAIR_WIDTH-1:0] r_pa, r_pb;
    logic signed [PROD_WIDTH-1:0] r_top, r_mix;
    logic signed [PROD_WIDTH-1:0] w_best;
    logic signed [EXT_WIDTH-1:0]  w_ext;
    logic        w_mul1, w_mul2, w_emit;
    logic        r_out_valid;
    t_out_item   r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_status.empty) n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_DONE;
            ST_DONE: if (w_emit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop  = 1'b0;
        w_mul1 = 1'b0;
        w_mul2 = 1'b0;
        w_emit = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop  = !i_status.empty;
            ST_MUL1: w_mul1 = 1'b1;
            ST_MUL2: w_mul2 = 1'b1;
            ST_DONE: w_emit = !r_out_valid || i_ready;
            default: o_pop  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: snapshot, pair products, triple products
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_snap <= i_snap;
        end
        if (w_mul1) begin
            r_pa <= PAIR_WIDTH'(r_snap.large1) * PAIR_WIDTH'(r_snap.large2);
            r_pb <= PAIR_WIDTH'(r_snap.small1) * PAIR_WIDTH'(r_snap.small2);
        end
        if (w_mul2) begin
            r_top <= PROD_WIDTH'(r_pa) * PROD_WIDTH'(r_snap.large3);
            r_mix <= PROD_WIDTH'(r_pb) * PROD_WIDTH'(r_snap.large1);
        end
    end

    // Larger product, zero for a short set
    assign w_best = !r_snap.ok ? '0 : ((r_top > r_mix) ? r_top : r_mix);
    assign w_ext  = EXT_WIDTH'(w_best);

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.product   <= w_ext[PRODUCT_WIDTH-1:0];
            r_out.valid_res <= r_snap.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_emit_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside done step");

    a_pop_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == ST_MUL1)
        else $error("popped snapshot not processed");

endmodule
